FILE: rtl/owtrs_pkg.sv
// Shared types, codes and the CRC-8 byte update for the one-wire temperature read sequencer.
// No dependencies.
package owtrs_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RST_A = 4'd1,
    PH_SEL_A = 4'd2,
    PH_CMD_A = 4'd3,
    PH_WAIT  = 4'd4,
    PH_RST_B = 4'd5,
    PH_SEL_B = 4'd6,
    PH_CMD_B = 4'd7,
    PH_READ  = 4'd8,
    PH_RST_C = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_RESET_DONE = 3'd1,
    OP_WRITE_DONE = 3'd2,
    OP_READ_DONE = 3'd3,
    OP_TICK = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REQ_RESET = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_DONE  = 2'd3
  } request_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_PRESENCE = 2'd1,
    ST_ALL_ONES    = 2'd2,
    ST_CRC_ERROR   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_SKIP_ROM   = 2'd0,
    REG_ROM_CODE   = 2'd1,
    REG_WAIT_TICKS = 2'd2
  } reg_index_e;

  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [3:0] ROM_BYTES     = 4'd8;
  localparam logic [3:0] PAD_BYTES     = 4'd9;
  localparam int         WAIT_W        = 20;
  localparam logic [WAIT_W-1:0] WAIT_RESET = 20'd750;

  // Reflected CRC-8, one data bit per step, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ data[i];
      crc = crc >> 1;
      if (mix) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

endpackage

FILE: rtl/one_wire_temperature_read_sequencer.sv
// One-wire temperature read sequencer: event in, bus request or done word out.
// Depends on owtrs_pkg.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: op[2:0]; tdata: presence[0] read_data[8:1]
// m_*      out  m_tvalid/m_tready  tuser: request[1:0]; tdata: write_data[7:0] status[9:8]
//                                         temperature_raw[25:10]
// apb      in   psel/penable       skip_rom @0x00, rom_code @0x08, wait_ticks @0x10
//
// One input word per cycle while s_tready is high; each word updates the sequence state in the cycle it is
// accepted and any result lands in the output register at that edge.
// s_tready drops only while the output register holds a word that m_tready refuses.
// Reset (rst_ni low, async) returns to idle with an empty output register and
// wait_ticks at 750.
module one_wire_temperature_read_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // op[2:0]
  input  logic [15:0] s_tdata,   // presence[0], read_data[8:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // request[1:0]
  output logic [31:0] m_tdata,   // write_data[7:0], status[9:8], temperature_raw[25:10]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int WAIT_W = owtrs_pkg::WAIT_W;

  // configuration
  logic              skip_rom_q;
  logic [63:0]       rom_code_q;
  logic [WAIT_W-1:0] wait_ticks_q;
  logic              cfg_we;
  logic [1:0]        cfg_index;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_rom_q   <= 1'b0;
      rom_code_q   <= '0;
      wait_ticks_q <= owtrs_pkg::WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owtrs_pkg::REG_SKIP_ROM:   skip_rom_q   <= pwdata[0];
        owtrs_pkg::REG_ROM_CODE:   rom_code_q   <= pwdata;
        owtrs_pkg::REG_WAIT_TICKS: wait_ticks_q <= pwdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      owtrs_pkg::REG_SKIP_ROM:   prdata = {63'd0, skip_rom_q};
      owtrs_pkg::REG_ROM_CODE:   prdata = rom_code_q;
      owtrs_pkg::REG_WAIT_TICKS: prdata = {{(64-WAIT_W){1'b0}}, wait_ticks_q};
      default:                   prdata = '0;
    endcase
  end

  // sequence state
  owtrs_pkg::phase_e phase_q, phase_d;
  logic [3:0]        byte_index_q, byte_index_d;
  logic [7:0]        crc_acc_q, crc_acc_d;
  logic              all_ones_q, all_ones_d;
  logic [7:0]        temp_lo_q, temp_lo_d;
  logic [7:0]        temp_hi_q, temp_hi_d;
  logic [WAIT_W-1:0] wait_count_q, wait_count_d;

  // output register
  logic        out_valid_q;
  logic [31:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q, out_user_d;
  logic        res_valid;
  owtrs_pkg::request_e res_request;
  logic [7:0]  res_write_data;
  owtrs_pkg::status_e  res_status;
  logic [15:0] res_temp;

  logic        in_acc;
  logic [2:0]  in_op;
  logic        in_presence;
  logic [7:0]  in_read_data;
  logic [3:0]  index_inc;
  logic [WAIT_W-1:0] wait_inc;
  logic [7:0]  rom_byte;

  assign s_tready     = !out_valid_q || m_tready;
  assign in_acc       = s_tvalid && s_tready;
  assign in_op        = s_tuser;
  assign in_presence  = s_tdata[0];
  assign in_read_data = s_tdata[8:1];
  assign index_inc    = byte_index_q + 4'd1;
  assign wait_inc     = wait_count_q + {{(WAIT_W-1){1'b0}}, 1'b1};
  assign rom_byte     = rom_code_q[{byte_index_q[2:0], 3'b000} +: 8];

  always_comb begin
    phase_d        = phase_q;
    byte_index_d   = byte_index_q;
    crc_acc_d      = crc_acc_q;
    all_ones_d     = all_ones_q;
    temp_lo_d      = temp_lo_q;
    temp_hi_d      = temp_hi_q;
    wait_count_d   = wait_count_q;
    res_valid      = 1'b0;
    res_request    = owtrs_pkg::REQ_RESET;
    res_write_data = 8'd0;
    res_status     = owtrs_pkg::ST_OK;
    res_temp       = 16'd0;

    unique case (phase_q)
      owtrs_pkg::PH_IDLE: begin
        if (in_op == owtrs_pkg::OP_START) begin
          phase_d     = owtrs_pkg::PH_RST_A;
          res_valid   = 1'b1;
          res_request = owtrs_pkg::REQ_RESET;
        end
      end
      owtrs_pkg::PH_RST_A, owtrs_pkg::PH_RST_B: begin
        if (in_op == owtrs_pkg::OP_RESET_DONE) begin
          res_valid   = 1'b1;
          res_request = owtrs_pkg::REQ_WRITE;
          if (!in_presence) begin
            phase_d     = owtrs_pkg::PH_IDLE;
            res_request = owtrs_pkg::REQ_DONE;
            res_status  = owtrs_pkg::ST_NO_PRESENCE;
          end else begin
            phase_d = (phase_q == owtrs_pkg::PH_RST_A) ? owtrs_pkg::PH_SEL_A
                                                       : owtrs_pkg::PH_SEL_B;
            // skip mode jumps straight past the ROM bytes
            if (skip_rom_q) begin
              byte_index_d   = owtrs_pkg::ROM_BYTES;
              res_write_data = owtrs_pkg::CMD_SKIP_ROM;
            end else begin
              byte_index_d   = 4'd0;
              res_write_data = owtrs_pkg::CMD_MATCH_ROM;
            end
          end
        end
      end
      owtrs_pkg::PH_SEL_A, owtrs_pkg::PH_SEL_B: begin
        if (in_op == owtrs_pkg::OP_WRITE_DONE) begin
          res_valid   = 1'b1;
          res_request = owtrs_pkg::REQ_WRITE;
          if (byte_index_q >= owtrs_pkg::ROM_BYTES) begin
            if (phase_q == owtrs_pkg::PH_SEL_A) begin
              phase_d        = owtrs_pkg::PH_CMD_A;
              res_write_data = owtrs_pkg::CMD_CONVERT;
            end else begin
              phase_d        = owtrs_pkg::PH_CMD_B;
              res_write_data = owtrs_pkg::CMD_READ_PAD;
            end
          end else begin
            byte_index_d   = index_inc;
            res_write_data = rom_byte;
          end
        end
      end
      owtrs_pkg::PH_CMD_A: begin
        if (in_op == owtrs_pkg::OP_WRITE_DONE) begin
          phase_d      = owtrs_pkg::PH_WAIT;
          wait_count_d = '0;
        end
      end
      owtrs_pkg::PH_WAIT: begin
        if (in_op == owtrs_pkg::OP_TICK) begin
          wait_count_d = wait_inc;
          if (wait_inc >= wait_ticks_q) begin
            phase_d     = owtrs_pkg::PH_RST_B;
            res_valid   = 1'b1;
            res_request = owtrs_pkg::REQ_RESET;
          end
        end
      end
      owtrs_pkg::PH_CMD_B: begin
        if (in_op == owtrs_pkg::OP_WRITE_DONE) begin
          phase_d      = owtrs_pkg::PH_READ;
          byte_index_d = 4'd0;
          crc_acc_d    = 8'd0;
          all_ones_d   = 1'b1;
          temp_lo_d    = 8'd0;
          temp_hi_d    = 8'd0;
          res_valid    = 1'b1;
          res_request  = owtrs_pkg::REQ_READ;
        end
      end
      owtrs_pkg::PH_READ: begin
        if (in_op == owtrs_pkg::OP_READ_DONE) begin
          if (in_read_data != owtrs_pkg::BYTE_ALL_ONES) all_ones_d = 1'b0;
          if (byte_index_q == 4'd0) temp_lo_d = in_read_data;
          if (byte_index_q == 4'd1) temp_hi_d = in_read_data;
          // CRC byte folds in by xor: zero left means match
          if (byte_index_q < owtrs_pkg::ROM_BYTES) begin
            crc_acc_d = owtrs_pkg::crc8_byte(crc_acc_q, in_read_data);
          end else begin
            crc_acc_d = crc_acc_q ^ in_read_data;
          end
          byte_index_d = index_inc;
          res_valid    = 1'b1;
          if (index_inc >= owtrs_pkg::PAD_BYTES) begin
            phase_d     = owtrs_pkg::PH_RST_C;
            res_request = owtrs_pkg::REQ_RESET;
          end else begin
            res_request = owtrs_pkg::REQ_READ;
          end
        end
      end
      owtrs_pkg::PH_RST_C: begin
        if (in_op == owtrs_pkg::OP_RESET_DONE) begin
          phase_d     = owtrs_pkg::PH_IDLE;
          res_valid   = 1'b1;
          res_request = owtrs_pkg::REQ_DONE;
          priority if (!in_presence) begin
            res_status = owtrs_pkg::ST_NO_PRESENCE;
          end else if (all_ones_q) begin
            res_status = owtrs_pkg::ST_ALL_ONES;
          end else if (crc_acc_q != 8'd0) begin
            res_status = owtrs_pkg::ST_CRC_ERROR;
          end else begin
            res_status = owtrs_pkg::ST_OK;
            res_temp   = {temp_hi_q, temp_lo_q};
          end
        end
      end
      default: begin
        phase_d = owtrs_pkg::PH_IDLE;
      end
    endcase

    out_data_d = {6'd0, res_temp, res_status, res_write_data};
    out_user_d = res_request;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= owtrs_pkg::PH_IDLE;
      byte_index_q <= 4'd0;
      crc_acc_q    <= 8'd0;
      all_ones_q   <= 1'b1;
      temp_lo_q    <= 8'd0;
      temp_hi_q    <= 8'd0;
      wait_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        byte_index_q <= byte_index_d;
        crc_acc_q    <= crc_acc_d;
        all_ones_q   <= all_ones_d;
        temp_lo_q    <= temp_lo_d;
        temp_hi_q    <= temp_hi_d;
        wait_count_q <= wait_count_d;
      end
      if (in_acc) begin
        out_valid_q <= res_valid;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload holds while a word waits
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;
  assign m_tuser  = out_user_q;

  a_ready_only_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> (out_valid_q && !m_tready))
    else $error("input stalled without a blocked output word");

  a_read_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == owtrs_pkg::PH_READ) |-> (byte_index_q < owtrs_pkg::PAD_BYTES))
    else $error("scratchpad index past last byte in read phase");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && res_request == owtrs_pkg::REQ_DONE)
      |=> (phase_q == owtrs_pkg::PH_IDLE && out_valid_q))
    else $error("done word without return to idle");

  a_temp_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[25:10] != 16'd0)
      |-> (out_user_q == owtrs_pkg::REQ_DONE && out_data_q[9:8] == owtrs_pkg::ST_OK))
    else $error("temperature reported outside a good done word");

endmodule

FILE: dv/one_wire_temperature_read_sequencer_test.sv
// Self-checking testbench for the one-wire temperature read sequencer: event words in,
// bus request and done words out, checked against an in-bench model of the sequence.
// Depends on owtrs_pkg and the one_wire_temperature_read_sequencer RTL.
`timescale 1ns / 1ps

module one_wire_temperature_read_sequencer_test;

  typedef struct packed {
    logic [7:0] read_data;
    logic       presence;
    logic [2:0] op;
  } sensor_event_t;

  typedef struct {
    owtrs_pkg::request_e request;
    logic [7:0]          write_data;
    owtrs_pkg::status_e  status;
    logic signed [15:0]  temperature;
  } bus_word_t;

  typedef enum int {PAD_GOOD, PAD_BAD_CRC, PAD_ALL_ONES, PAD_RANDOM} pad_flavor_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [2:0]  s_tuser;   // op[2:0]
  logic [15:0] s_tdata;   // presence[0], read_data[8:1]
  logic        m_tvalid;
  logic        m_tready;
  logic [1:0]  m_tuser;   // request[1:0]
  logic [31:0] m_tdata;   // write_data[7:0], status[9:8], temperature_raw[25:10]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  one_wire_temperature_read_sequencer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sensor_event_t pending_events[$];
  bus_word_t     expected_words[$];
  sensor_event_t drive_ev;
  int            error_count = 0;
  bit            in_taken = 1'b0;
  bit            calm = 1'b0;
  int            in_gap = 0;
  int            out_gap = 0;

  // Register copies and sequence state of the model
  logic              cfg_skip_rom;
  logic [63:0]       cfg_rom_code;
  logic [19:0]       cfg_wait_ticks;
  owtrs_pkg::phase_e sq_phase;
  logic [3:0]        sq_index;
  logic [7:0]        sq_crc;
  logic              sq_all_ones;
  logic [7:0]        sq_temp_lo;
  logic [7:0]        sq_temp_hi;
  logic [19:0]       sq_wait_count;

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] maxim_crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      acc = acc[0] ? ((acc >> 1) ^ owtrs_pkg::CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic sensor_event_t make_event(input logic [2:0] op, input logic pres,
                                               input logic [7:0] data);
    sensor_event_t ev;
    ev.op = op;
    ev.presence = pres;
    ev.read_data = data;
    return ev;
  endfunction

  // Model of one accepted event word; queues the word it causes, if any.
  task automatic step_sequencer(input sensor_event_t ev);
    bus_word_t w;
    bit        emit_word;
    emit_word = 1'b0;
    w.request = owtrs_pkg::REQ_RESET;
    w.write_data = 8'h00;
    w.status = owtrs_pkg::ST_OK;
    w.temperature = 16'sd0;
    case (sq_phase)
      owtrs_pkg::PH_IDLE: begin
        if (ev.op == owtrs_pkg::OP_START) begin
          sq_phase = owtrs_pkg::PH_RST_A;
          emit_word = 1'b1;
        end
      end
      owtrs_pkg::PH_RST_A, owtrs_pkg::PH_RST_B: begin
        if (ev.op == owtrs_pkg::OP_RESET_DONE) begin
          emit_word = 1'b1;
          if (!ev.presence) begin
            sq_phase = owtrs_pkg::PH_IDLE;
            w.request = owtrs_pkg::REQ_DONE;
            w.status = owtrs_pkg::ST_NO_PRESENCE;
          end else begin
            sq_phase = (sq_phase == owtrs_pkg::PH_RST_A) ? owtrs_pkg::PH_SEL_A
                                                         : owtrs_pkg::PH_SEL_B;
            w.request = owtrs_pkg::REQ_WRITE;
            if (cfg_skip_rom) begin
              sq_index = owtrs_pkg::ROM_BYTES;
              w.write_data = owtrs_pkg::CMD_SKIP_ROM;
            end else begin
              sq_index = 4'd0;
              w.write_data = owtrs_pkg::CMD_MATCH_ROM;
            end
          end
        end
      end
      owtrs_pkg::PH_SEL_A, owtrs_pkg::PH_SEL_B: begin
        if (ev.op == owtrs_pkg::OP_WRITE_DONE) begin
          emit_word = 1'b1;
          w.request = owtrs_pkg::REQ_WRITE;
          if (sq_index >= owtrs_pkg::ROM_BYTES) begin
            w.write_data = (sq_phase == owtrs_pkg::PH_SEL_A) ? owtrs_pkg::CMD_CONVERT
                                                             : owtrs_pkg::CMD_READ_PAD;
            sq_phase = (sq_phase == owtrs_pkg::PH_SEL_A) ? owtrs_pkg::PH_CMD_A
                                                         : owtrs_pkg::PH_CMD_B;
          end else begin
            w.write_data = cfg_rom_code[{sq_index[2:0], 3'b000} +: 8];
            sq_index = sq_index + 4'd1;
          end
        end
      end
      owtrs_pkg::PH_CMD_A: begin
        if (ev.op == owtrs_pkg::OP_WRITE_DONE) begin
          sq_phase = owtrs_pkg::PH_WAIT;
          sq_wait_count = '0;
        end
      end
      owtrs_pkg::PH_WAIT: begin
        if (ev.op == owtrs_pkg::OP_TICK) begin
          sq_wait_count = sq_wait_count + 20'd1;
          if (sq_wait_count >= cfg_wait_ticks) begin
            sq_phase = owtrs_pkg::PH_RST_B;
            emit_word = 1'b1;
          end
        end
      end
      owtrs_pkg::PH_CMD_B: begin
        if (ev.op == owtrs_pkg::OP_WRITE_DONE) begin
          sq_phase = owtrs_pkg::PH_READ;
          sq_index = 4'd0;
          sq_crc = 8'h00;
          sq_all_ones = 1'b1;
          sq_temp_lo = 8'h00;
          sq_temp_hi = 8'h00;
          emit_word = 1'b1;
          w.request = owtrs_pkg::REQ_READ;
        end
      end
      owtrs_pkg::PH_READ: begin
        if (ev.op == owtrs_pkg::OP_READ_DONE) begin
          emit_word = 1'b1;
          if (ev.read_data != owtrs_pkg::BYTE_ALL_ONES) sq_all_ones = 1'b0;
          if (sq_index == 4'd0) sq_temp_lo = ev.read_data;
          if (sq_index == 4'd1) sq_temp_hi = ev.read_data;
          // the last byte is the CRC itself: a match leaves zero
          if (sq_index < owtrs_pkg::ROM_BYTES) sq_crc = maxim_crc_step(sq_crc, ev.read_data);
          else sq_crc = sq_crc ^ ev.read_data;
          sq_index = sq_index + 4'd1;
          if (sq_index >= owtrs_pkg::PAD_BYTES) begin
            sq_phase = owtrs_pkg::PH_RST_C;
          end else begin
            w.request = owtrs_pkg::REQ_READ;
          end
        end
      end
      owtrs_pkg::PH_RST_C: begin
        if (ev.op == owtrs_pkg::OP_RESET_DONE) begin
          emit_word = 1'b1;
          sq_phase = owtrs_pkg::PH_IDLE;
          w.request = owtrs_pkg::REQ_DONE;
          if (!ev.presence) w.status = owtrs_pkg::ST_NO_PRESENCE;
          else if (sq_all_ones) w.status = owtrs_pkg::ST_ALL_ONES;
          else if (sq_crc != 8'h00) w.status = owtrs_pkg::ST_CRC_ERROR;
          else w.temperature = {sq_temp_hi, sq_temp_lo};
        end
      end
      default: sq_phase = owtrs_pkg::PH_IDLE;
    endcase
    if (emit_word) expected_words.push_back(w);
  endtask

  task automatic check_bus_word(input logic [1:0] user, input logic [31:0] data);
    bus_word_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected result word %h %h", user, data);
      error_count++;
    end else begin
      want = expected_words.pop_front();
      if (user !== want.request) begin
        $error("request: expected %0d, got %0d", want.request, user);
        error_count++;
      end
      if (data[7:0] !== want.write_data) begin
        $error("write_data: expected %h, got %h", want.write_data, data[7:0]);
        error_count++;
      end
      if (data[9:8] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, data[9:8]);
        error_count++;
      end
      if (data[25:10] !== want.temperature) begin
        $error("temperature_raw: expected %0d, got %0d", want.temperature,
               $signed(data[25:10]));
        error_count++;
      end
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    in_taken = s_tvalid && s_tready;
    if (rst_ni) begin
      if (m_tvalid && m_tready) check_bus_word(m_tuser, m_tdata);
      if (s_tvalid && s_tready) step_sequencer(make_event(s_tuser, s_tdata[0], s_tdata[8:1]));
    end
  end

  // Event word driver: hold until taken, idle in short bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      s_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      s_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_events.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      in_gap <= $urandom_range(0, 2);
    end else if (pending_events.size() != 0) begin
      drive_ev = pending_events.pop_front();
      s_tvalid <= 1'b1;
      s_tuser <= drive_ev.op;
      s_tdata <= {7'd0, drive_ev.read_data, drive_ev.presence};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result sink: stall in short bursts
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      m_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      out_gap <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_register(input owtrs_pkg::reg_index_e idx, input logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      owtrs_pkg::REG_SKIP_ROM:   cfg_skip_rom = value[0];
      owtrs_pkg::REG_ROM_CODE:   cfg_rom_code = value;
      owtrs_pkg::REG_WAIT_TICKS: cfg_wait_ticks = value[19:0];
      default: ;
    endcase
  endtask

  // Drop a random word in front now and then when noisy
  task automatic queue_event(input logic [2:0] op, input logic pres, input logic [7:0] data,
                             input bit noisy);
    if (noisy && $urandom_range(0, 19) == 0) begin
      pending_events.push_back(make_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                          8'($urandom_range(0, 255))));
    end
    pending_events.push_back(make_event(op, pres, data));
  endtask

  task automatic queue_select(input bit noisy);
    int n_writes;
    n_writes = cfg_skip_rom ? 2 : 10;   // ROM command, address bytes and the function command
    for (int i = 0; i < n_writes; i++) begin
      queue_event(owtrs_pkg::OP_WRITE_DONE, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), noisy);
    end
  endtask

  task automatic queue_scratchpad(input logic [7:0] lo, input logic [7:0] hi,
                                  input pad_flavor_e flavor, input bit noisy);
    logic [7:0] pad [9];
    logic [7:0] crc;
    crc = 8'h00;
    pad[0] = lo;
    pad[1] = hi;
    for (int i = 2; i < 8; i++) pad[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++) crc = maxim_crc_step(crc, pad[i]);
    pad[8] = crc;
    case (flavor)
      PAD_BAD_CRC:  pad[8] = pad[8] ^ 8'($urandom_range(1, 255));
      PAD_ALL_ONES: for (int i = 0; i < 9; i++) pad[i] = owtrs_pkg::BYTE_ALL_ONES;
      PAD_RANDOM:   for (int i = 0; i < 9; i++) pad[i] = 8'($urandom_range(0, 255));
      default: ;
    endcase
    for (int i = 0; i < 9; i++) begin
      queue_event(owtrs_pkg::OP_READ_DONE, 1'($urandom_range(0, 1)), pad[i], noisy);
    end
  endtask

  // One full measurement as the bus engine would report it
  task automatic queue_measurement(input bit noisy, input bit clean_bus);
    logic        pres;
    logic [15:0] temp;
    int          roll;
    int          n_ticks;
    pad_flavor_e flavor;
    queue_event(owtrs_pkg::OP_START, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                noisy);
    pres = clean_bus || ($urandom_range(0, 11) != 0);
    queue_event(owtrs_pkg::OP_RESET_DONE, pres, 8'($urandom_range(0, 255)), noisy);
    if (!pres) return;
    queue_select(noisy);
    n_ticks = (cfg_wait_ticks == 0) ? 1 : int'(cfg_wait_ticks);
    for (int i = 0; i < n_ticks; i++) begin
      queue_event(owtrs_pkg::OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  noisy);
    end
    pres = clean_bus || ($urandom_range(0, 11) != 0);
    queue_event(owtrs_pkg::OP_RESET_DONE, pres, 8'($urandom_range(0, 255)), noisy);
    if (!pres) return;
    queue_select(noisy);
    roll = $urandom_range(0, 9);
    case (roll)
      0: temp = 16'h8000;
      1: temp = 16'h7FFF;
      2: temp = 16'h0000;
      default: temp = 16'($urandom_range(0, 65535));
    endcase
    roll = $urandom_range(0, 19);
    if (clean_bus || roll > 5) flavor = PAD_GOOD;
    else if (roll < 2) flavor = PAD_ALL_ONES;
    else if (roll < 5) flavor = PAD_BAD_CRC;
    else flavor = PAD_RANDOM;
    queue_scratchpad(temp[7:0], temp[15:8], flavor, noisy);
    pres = clean_bus || ($urandom_range(0, 11) != 0);
    queue_event(owtrs_pkg::OP_RESET_DONE, pres, 8'($urandom_range(0, 255)), noisy);
  endtask

  task automatic wait_quiet();
    while (pending_events.size() != 0 || s_tvalid || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  // Feed whatever the current phase needs until the sequencer is back in idle
  task automatic settle_idle();
    wait_quiet();
    while (sq_phase != owtrs_pkg::PH_IDLE) begin
      case (sq_phase)
        owtrs_pkg::PH_RST_A, owtrs_pkg::PH_RST_B, owtrs_pkg::PH_RST_C:
          pending_events.push_back(make_event(owtrs_pkg::OP_RESET_DONE, 1'b0, 8'h00));
        owtrs_pkg::PH_WAIT:
          pending_events.push_back(make_event(owtrs_pkg::OP_TICK, 1'b0, 8'h00));
        owtrs_pkg::PH_READ:
          pending_events.push_back(make_event(owtrs_pkg::OP_READ_DONE, 1'b0, 8'h5A));
        default:
          pending_events.push_back(make_event(owtrs_pkg::OP_WRITE_DONE, 1'b0, 8'h00));
      endcase
      wait_quiet();
    end
  endtask

  initial begin
    #(60_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_skip_rom = 1'b0;
    cfg_rom_code = '0;
    cfg_wait_ticks = owtrs_pkg::WAIT_RESET;
    sq_phase = owtrs_pkg::PH_IDLE;
    sq_index = 4'd0;
    sq_crc = 8'h00;
    sq_all_ones = 1'b1;
    sq_temp_lo = 8'h00;
    sq_temp_hi = 8'h00;
    sq_wait_count = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Words that idle ignores, then a start with no presence
    queue_event(3'($urandom_range(5, 7)), 1'b1, 8'hFF, 1'b0);
    queue_event(3'($urandom_range(5, 7)), 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_TICK, 1'b1, 8'hA5, 1'b0);
    queue_event(owtrs_pkg::OP_READ_DONE, 1'b1, 8'h3C, 1'b0);
    queue_event(owtrs_pkg::OP_START, 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_RESET_DONE, 1'b0, 8'h00, 1'b0);
    settle_idle();

    write_register(owtrs_pkg::REG_SKIP_ROM, 64'd1);
    write_register(owtrs_pkg::REG_WAIT_TICKS, 64'd1);
    // Skip-ROM read with a busy start, a stray tick and the most negative reading
    queue_event(owtrs_pkg::OP_START, 1'b1, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_START, 1'b1, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_RESET_DONE, 1'b1, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_WRITE_DONE, 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_TICK, 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_WRITE_DONE, 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_TICK, 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_RESET_DONE, 1'b1, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_WRITE_DONE, 1'b0, 8'h00, 1'b0);
    queue_event(owtrs_pkg::OP_WRITE_DONE, 1'b0, 8'h00, 1'b0);
    queue_scratchpad(8'h00, 8'h80, PAD_GOOD, 1'b0);
    queue_event(owtrs_pkg::OP_RESET_DONE, 1'b1, 8'h00, 1'b0);
    settle_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          write_register(owtrs_pkg::REG_SKIP_ROM, 64'd0);
          write_register(owtrs_pkg::REG_ROM_CODE, 64'd0);
          write_register(owtrs_pkg::REG_WAIT_TICKS, 64'd0);
        end
        1: begin
          write_register(owtrs_pkg::REG_SKIP_ROM, 64'd0);
          write_register(owtrs_pkg::REG_ROM_CODE, {64{1'b1}});
          write_register(owtrs_pkg::REG_WAIT_TICKS, 64'd1);
        end
        2: begin
          write_register(owtrs_pkg::REG_SKIP_ROM, 64'd1);
          write_register(owtrs_pkg::REG_ROM_CODE, {$urandom, $urandom});
          write_register(owtrs_pkg::REG_WAIT_TICKS, 64'd2);
        end
        default: begin
          write_register(owtrs_pkg::REG_SKIP_ROM, 64'($urandom_range(0, 1)));
          write_register(owtrs_pkg::REG_ROM_CODE, {$urandom, $urandom});
          write_register(owtrs_pkg::REG_WAIT_TICKS, 64'($urandom_range(1, 6)));
        end
      endcase
      repeat (2) queue_measurement(1'b1, 1'b0);
      settle_idle();
    end

    // Longer conversion wait, back to back on both sides
    calm = 1'b1;
    write_register(owtrs_pkg::REG_SKIP_ROM, 64'd0);
    write_register(owtrs_pkg::REG_ROM_CODE, {$urandom, $urandom});
    write_register(owtrs_pkg::REG_WAIT_TICKS, 64'd12);
    queue_measurement(1'b0, 1'b1);
    wait_quiet();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/owtrs_pkg.sv
rtl/one_wire_temperature_read_sequencer.sv
dv/one_wire_temperature_read_sequencer_test.sv
